// ----- rtl/wpd_pkg.sv -----
// ----------------------------------------------------------------------------
// wpd_pkg
// Shared types and constants of the waveform peak decimator: item structs,
// clamped configuration bundle, command flags and register map.
// ----------------------------------------------------------------------------
package wpd_pkg;

  // Input item: one interleaved channel sample
  typedef struct packed {
    logic signed [15:0] sample;
    logic               end_of_stream;
  } in_item_t;

  // Result item: one peak pair
  typedef struct packed {
    logic               level;
    logic signed [15:0] peak_min;
    logic signed [15:0] peak_max;
    logic               last;
  } out_item_t;

  // Configuration after clamping to the legal ranges
  typedef struct packed {
    logic [4:0]  ch;   // channels per frame, 1..15
    logic [16:0] cf;   // frames per chunk, 1..8191
    logic [6:0]  mf;   // chunks per group, 1..64
  } cfg_t;

  // What the front hands to the back for one item
  typedef struct packed {
    logic do_chunk;    // a chunk closed, its sums travel with the command
    logic eos;         // end of stream, flush the group tail
  } cmd_flags_t;

  // Register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_CHANNEL_COUNT = 2'd0;
  localparam logic [1:0] REG_CHUNK_FRAMES  = 2'd1;
  localparam logic [1:0] REG_MIPMAP_FACTOR = 2'd2;

  // Register reset values
  localparam logic [3:0]  RST_CHANNEL_COUNT = 4'd1;
  localparam logic [12:0] RST_CHUNK_FRAMES  = 13'd128;
  localparam logic [6:0]  RST_MIPMAP_FACTOR = 7'd10;

  localparam logic [6:0] MAX_MIPMAP = 7'd64;

  // Result levels
  localparam logic LEVEL_CHUNK = 1'b0;
  localparam logic LEVEL_GROUP = 1'b1;

endpackage

// ----- rtl/wpd_fifo.sv -----
// ----------------------------------------------------------------------------
// wpd_fifo
// Small register queue with first-word fall-through read.
// ----------------------------------------------------------------------------
module wpd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ----- rtl/wpd_front.sv -----
// ----------------------------------------------------------------------------
// wpd_front
// Accepts samples, builds frame sums, tracks chunk min/max and issues a
// command to the back end when a chunk closes or the stream ends.
// ----------------------------------------------------------------------------
module wpd_front
  import wpd_pkg::*;
#(
  parameter int SUM_W   = 19,
  parameter int CHAN_W  = 3,
  parameter int FRAME_W = 12
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cfg_t                    cfg_i,
  input  in_item_t                item_i,
  input  logic                    accept_i,
  output logic                    cmd_push_o,
  output cmd_flags_t              cmd_flags_o,
  output logic signed [SUM_W-1:0] cmd_min_sum_o,
  output logic signed [SUM_W-1:0] cmd_max_sum_o
);

  logic [CHAN_W-1:0]       pos_q, pos_d;
  logic signed [SUM_W-1:0] frame_sum_q, frame_sum_d;
  logic signed [SUM_W-1:0] cmin_q, cmin_d;
  logic signed [SUM_W-1:0] cmax_q, cmax_d;
  logic [FRAME_W-1:0]      frames_q, frames_d;

  logic signed [SUM_W-1:0] sample_ext;
  logic signed [SUM_W-1:0] fsum;
  logic signed [SUM_W-1:0] cmin_new, cmax_new;
  logic [FRAME_W-1:0]      frames_after;
  logic                    frame_done, chunk_done, do_chunk;

  // Frame and chunk bookkeeping for the item at the input
  always_comb begin
    sample_ext   = SUM_W'(item_i.sample);
    fsum         = frame_sum_q + sample_ext;
    frame_done   = (5'(pos_q) + 5'd1) >= cfg_i.ch;
    chunk_done   = frame_done && ((17'(frames_q) + 17'd1) >= cfg_i.cf);
    cmin_new     = cmin_q;
    cmax_new     = cmax_q;
    if (frame_done && (fsum < cmin_q)) begin
      cmin_new = fsum;
    end
    if (frame_done && (fsum > cmax_q)) begin
      cmax_new = fsum;
    end
    if (!frame_done) begin
      frames_after = frames_q;
    end else if (chunk_done) begin
      frames_after = '0;
    end else begin
      frames_after = frames_q + FRAME_W'(1);
    end
    // a partial chunk is flushed at end of stream
    do_chunk = chunk_done || (item_i.end_of_stream && (frames_after != '0));
  end

  assign cmd_push_o            = accept_i && (do_chunk || item_i.end_of_stream);
  assign cmd_flags_o.do_chunk  = do_chunk;
  assign cmd_flags_o.eos       = item_i.end_of_stream;
  assign cmd_min_sum_o         = cmin_new;
  assign cmd_max_sum_o         = cmax_new;

  // Next state
  always_comb begin
    pos_d       = pos_q;
    frame_sum_d = frame_sum_q;
    cmin_d      = cmin_q;
    cmax_d      = cmax_q;
    frames_d    = frames_q;
    if (accept_i) begin
      if (item_i.end_of_stream) begin
        pos_d       = '0;
        frame_sum_d = '0;
        cmin_d      = '0;
        cmax_d      = '0;
        frames_d    = '0;
      end else if (frame_done) begin
        pos_d       = '0;
        frame_sum_d = '0;
        frames_d    = frames_after;
        cmin_d      = chunk_done ? '0 : cmin_new;
        cmax_d      = chunk_done ? '0 : cmax_new;
      end else begin
        pos_d       = pos_q + CHAN_W'(1);
        frame_sum_d = fsum;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      frame_sum_q <= '0;
      cmin_q      <= '0;
      cmax_q      <= '0;
      frames_q    <= '0;
    end else begin
      pos_q       <= pos_d;
      frame_sum_q <= frame_sum_d;
      cmin_q      <= cmin_d;
      cmax_q      <= cmax_d;
      frames_q    <= frames_d;
    end
  end

endmodule

// ----- rtl/wpd_div.sv -----
// ----------------------------------------------------------------------------
// wpd_div
// Scales a min/max sum pair by 32767/(32768*ch), truncating toward zero.
// Two lanes of a restoring divider, four quotient bits per cycle.
// ----------------------------------------------------------------------------
module wpd_div #(
  parameter int SUM_W = 19
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [4:0]              ch_i,
  input  logic signed [SUM_W-1:0] min_sum_i,
  input  logic signed [SUM_W-1:0] max_sum_i,
  output logic                    done_o,
  output logic signed [SUM_W-1:0] peak_min_o,
  output logic signed [SUM_W-1:0] peak_max_o
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_PREP = 2'd1;
  localparam logic [1:0] PH_STEP = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  // quotient covers the full scaled magnitude, four bits per step cycle
  localparam int Steps = (SUM_W + 3) / 4;
  localparam int QuoW  = 4 * Steps;
  localparam int StepW = $clog2(Steps + 1);

  logic [1:0]       phase_q, phase_d;
  logic [StepW-1:0] step_q, step_d;

  // lane 0 carries the minimum, lane 1 the maximum
  logic signed [SUM_W-1:0] sum_q [2];
  logic                    neg_q [2];
  logic [QuoW-1:0]         quo_q [2];
  logic [QuoW-1:0]         quo_d [2];
  logic [3:0]              rem_q [2];
  logic [3:0]              rem_d [2];

  // Phase sequencing
  always_comb begin
    phase_d = phase_q;
    step_d  = step_q;
    case (phase_q)
      PH_IDLE: begin
        if (start_i) begin
          phase_d = PH_PREP;
        end
      end
      PH_PREP: begin
        phase_d = PH_STEP;
        step_d  = '0;
      end
      PH_STEP: begin
        step_d = step_q + StepW'(1);
        if (step_q == StepW'(Steps - 1)) begin
          phase_d = PH_DONE;
        end
      end
      PH_DONE: begin
        phase_d = PH_IDLE;
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      step_q  <= '0;
    end else begin
      phase_q <= phase_d;
      step_q  <= step_d;
    end
  end

  // Per-lane datapath
  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [SUM_W-1:0]    mag;
    logic [SUM_W+14:0]   prod;
    logic [SUM_W-1:0]    scaled;
    logic [4:0]          trial;
    logic [3:0]          rem_w;
    logic [QuoW-1:0]     quo_w;

    always_comb begin
      // |sum| * 32767 / 32768, floored
      mag    = sum_q[l][SUM_W-1] ? SUM_W'(-sum_q[l]) : SUM_W'(sum_q[l]);
      prod   = {mag, 15'd0} - (SUM_W + 15)'(mag);
      scaled = prod[SUM_W+14:15];
      // four restoring steps; remainder stays below ch
      rem_w  = rem_q[l];
      quo_w  = quo_q[l];
      trial  = '0;
      for (int k = 0; k < 4; k++) begin
        trial = {rem_w, quo_w[QuoW-1]};
        quo_w = {quo_w[QuoW-2:0], 1'b0};
        if (trial >= ch_i) begin
          rem_w    = 4'(trial - ch_i);
          quo_w[0] = 1'b1;
        end else begin
          rem_w = trial[3:0];
        end
      end
      rem_d[l] = rem_q[l];
      quo_d[l] = quo_q[l];
      if (phase_q == PH_PREP) begin
        rem_d[l] = '0;
        quo_d[l] = QuoW'(scaled);
      end else if (phase_q == PH_STEP) begin
        rem_d[l] = rem_w;
        quo_d[l] = quo_w;
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i && (phase_q == PH_IDLE)) begin
        sum_q[l] <= (l == 0) ? min_sum_i : max_sum_i;
      end
      if (phase_q == PH_PREP) begin
        neg_q[l] <= sum_q[l][SUM_W-1];
      end
      rem_q[l] <= rem_d[l];
      quo_q[l] <= quo_d[l];
    end
  end

  assign done_o     = (phase_q == PH_DONE);
  assign peak_min_o = neg_q[0] ? -$signed(quo_q[0][SUM_W-1:0])
                               : $signed(quo_q[0][SUM_W-1:0]);
  assign peak_max_o = neg_q[1] ? -$signed(quo_q[1][SUM_W-1:0])
                               : $signed(quo_q[1][SUM_W-1:0]);

  // Checks
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("divider done held for more than one cycle");

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> (phase_q == PH_IDLE))
    else $error("divider started while busy");

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (({1'b0, rem_q[0]} < ch_i) && ({1'b0, rem_q[1]} < ch_i)))
    else $error("divider remainder not below channel count");

endmodule

// ----- rtl/wpd_back.sv -----
// ----------------------------------------------------------------------------
// wpd_back
// Executes commands: scales chunk peaks, emits level-0 pairs, folds them into
// the mipmap group and emits level-1 pairs on group close or stream end.
// ----------------------------------------------------------------------------
module wpd_back
  import wpd_pkg::*;
#(
  parameter int SUM_W = 19
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cfg_t                    cfg_i,
  input  logic                    cmd_empty_i,
  input  cmd_flags_t              cmd_flags_i,
  input  logic signed [SUM_W-1:0] cmd_min_sum_i,
  input  logic signed [SUM_W-1:0] cmd_max_sum_i,
  output logic                    cmd_pop_o,
  input  logic                    out_full_i,
  output logic                    out_push_o,
  output out_item_t               out_item_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DIV   = 2'd1;
  localparam logic [1:0] ST_EMIT0 = 2'd2;
  localparam logic [1:0] ST_EMIT1 = 2'd3;

  logic [1:0]              state_q, state_d;
  logic                    eos_q, eos_d;
  logic [5:0]              chunks_q, chunks_d;
  // group extremes keep the full scaled width; results carry the low 16 bits
  logic signed [SUM_W-1:0] gmin_q, gmin_d;
  logic signed [SUM_W-1:0] gmax_q, gmax_d;
  logic                    tail_q, tail_d;

  logic                    div_start, div_done;
  logic signed [SUM_W-1:0] pmin, pmax;
  logic signed [SUM_W-1:0] fold_min, fold_max;
  logic                    close_grp;

  wpd_div #(
    .SUM_W (SUM_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .ch_i       (cfg_i.ch),
    .min_sum_i  (cmd_min_sum_i),
    .max_sum_i  (cmd_max_sum_i),
    .done_o     (div_done),
    .peak_min_o (pmin),
    .peak_max_o (pmax)
  );

  assign fold_min  = (pmin < gmin_q) ? pmin : gmin_q;
  assign fold_max  = (pmax > gmax_q) ? pmax : gmax_q;
  assign close_grp = ({1'b0, chunks_q} + 7'd1) >= cfg_i.mf;

  // Command sequencer
  always_comb begin
    state_d    = state_q;
    eos_d      = eos_q;
    chunks_d   = chunks_q;
    gmin_d     = gmin_q;
    gmax_d     = gmax_q;
    tail_d     = tail_q;
    cmd_pop_o  = 1'b0;
    div_start  = 1'b0;
    out_push_o = 1'b0;
    out_item_o = '0;
    case (state_q)
      ST_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          if (cmd_flags_i.do_chunk) begin
            div_start = 1'b1;
            eos_d     = cmd_flags_i.eos;
            state_d   = ST_DIV;
          end else if (tail_q) begin
            // end of stream with only a group tail pending
            state_d = ST_EMIT1;
          end else begin
            chunks_d = '0;
            gmin_d   = '0;
            gmax_d   = '0;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_EMIT0;
        end
      end
      ST_EMIT0: begin
        out_item_o.level    = LEVEL_CHUNK;
        out_item_o.peak_min = pmin[15:0];
        out_item_o.peak_max = pmax[15:0];
        out_item_o.last     = !(close_grp || eos_q);
        if (!out_full_i) begin
          out_push_o = 1'b1;
          gmin_d     = fold_min;
          gmax_d     = fold_max;
          if (close_grp) begin
            state_d = ST_EMIT1;
          end else begin
            chunks_d = chunks_q + 6'd1;
            tail_d   = 1'b1;
            state_d  = eos_q ? ST_EMIT1 : ST_IDLE;
          end
        end
      end
      ST_EMIT1: begin
        out_item_o.level    = LEVEL_GROUP;
        out_item_o.peak_min = gmin_q[15:0];
        out_item_o.peak_max = gmax_q[15:0];
        out_item_o.last     = 1'b1;
        if (!out_full_i) begin
          out_push_o = 1'b1;
          chunks_d   = '0;
          gmin_d     = '0;
          gmax_d     = '0;
          tail_d     = 1'b0;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      eos_q    <= 1'b0;
      chunks_q <= '0;
      gmin_q   <= '0;
      gmax_q   <= '0;
      tail_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      eos_q    <= eos_d;
      chunks_q <= chunks_d;
      gmin_q   <= gmin_d;
      gmax_q   <= gmax_d;
      tail_q   <= tail_d;
    end
  end

  // Checks
  a_tail_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_q == (chunks_q != '0))
    else $error("group tail flag disagrees with chunk count");

  a_group_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (gmin_q <= SUM_W'(0)) && (gmax_q >= SUM_W'(0)))
    else $error("group peaks crossed zero");

endmodule

// ----- rtl/waveform_peak_decimator_unit.sv -----
// ----------------------------------------------------------------------------
// waveform_peak_decimator_unit
// Min/max peak decimation of interleaved audio with a one-step mipmap.
// ----------------------------------------------------------------------------
// Input channel: one signed Q1.15 sample per item in interleaved channel
// order, pushed with push while full is low; end_of_stream marks the final
// sample and flushes a partial chunk and the mipmap tail.
// Result channel: peak pairs wait in a two-entry queue; the oldest is on
// out_item_o while empty is low and leaves on pop. level 0 is a chunk pair,
// level 1 a group pair; last flags the final result of one input item.
// An item that closes no chunk and does not end the stream only updates the
// front end. A closing item holds the back end through a command pop, a
// scaling step, the steps of the two-lane divider (four quotient bits per
// cycle) and a handoff step before its first result, then through one push
// per result. A two-entry command queue lets the front keep taking samples
// meanwhile; full rises only when it fills.
// Reset clears all stream state and loads channel_count 1, chunk_frames 128
// and mipmap_factor 10. A stalled receiver backs up the result queue, then
// the back end, then the command queue, and finally raises full.
// Registers sit on an APB port at byte addresses 0, 4 and 8; write them only
// while the block is idle.
// ----------------------------------------------------------------------------
module waveform_peak_decimator_unit
  import wpd_pkg::*;
#(
  parameter int MAX_CHANNELS     = 8,
  parameter int MAX_CHUNK_FRAMES = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // sample queue
  input  logic        push,
  output logic        full,
  input  in_item_t    in_item_i,
  // result queue
  output logic        empty,
  input  logic        pop,
  output out_item_t   out_item_o,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int SumW   = 16 + $clog2(MAX_CHANNELS);
  localparam int ChanW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int FrameW = (MAX_CHUNK_FRAMES > 1) ? $clog2(MAX_CHUNK_FRAMES) : 1;
  localparam int FlagW  = $bits(cmd_flags_t);
  localparam int CmdW   = FlagW + 2 * SumW;
  localparam int OutW   = $bits(out_item_t);

  // Configuration registers
  logic [3:0]  ch_raw_q;
  logic [12:0] cf_raw_q;
  logic [6:0]  mf_raw_q;
  logic        cfg_wr;
  cfg_t        cfg;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_raw_q <= RST_CHANNEL_COUNT;
      cf_raw_q <= RST_CHUNK_FRAMES;
      mf_raw_q <= RST_MIPMAP_FACTOR;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_CHANNEL_COUNT: ch_raw_q <= pwdata[3:0];
        REG_CHUNK_FRAMES:  cf_raw_q <= pwdata[12:0];
        REG_MIPMAP_FACTOR: mf_raw_q <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_CHANNEL_COUNT: prdata = 32'(ch_raw_q);
      REG_CHUNK_FRAMES:  prdata = 32'(cf_raw_q);
      REG_MIPMAP_FACTOR: prdata = 32'(mf_raw_q);
      default:           prdata = '0;
    endcase
  end

  // Clamp: zero counts as one, large values saturate
  always_comb begin
    if (ch_raw_q == '0) begin
      cfg.ch = 5'd1;
    end else if (5'(ch_raw_q) > 5'(MAX_CHANNELS)) begin
      cfg.ch = 5'(MAX_CHANNELS);
    end else begin
      cfg.ch = 5'(ch_raw_q);
    end
    if (cf_raw_q == '0) begin
      cfg.cf = 17'd1;
    end else if (17'(cf_raw_q) > 17'(MAX_CHUNK_FRAMES)) begin
      cfg.cf = 17'(MAX_CHUNK_FRAMES);
    end else begin
      cfg.cf = 17'(cf_raw_q);
    end
    if (mf_raw_q == '0) begin
      cfg.mf = 7'd1;
    end else if (mf_raw_q > MAX_MIPMAP) begin
      cfg.mf = MAX_MIPMAP;
    end else begin
      cfg.mf = mf_raw_q;
    end
  end

  // Front end
  logic                   in_accept;
  logic                   cmd_push, cmd_pop, cmd_full, cmd_empty;
  cmd_flags_t             f_flags, b_flags;
  logic signed [SumW-1:0] f_min_sum, f_max_sum, b_min_sum, b_max_sum;
  logic [CmdW-1:0]        cmd_wdata, cmd_rdata;

  assign full      = cmd_full;
  assign in_accept = push && !cmd_full;

  wpd_front #(
    .SUM_W   (SumW),
    .CHAN_W  (ChanW),
    .FRAME_W (FrameW)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .item_i        (in_item_i),
    .accept_i      (in_accept),
    .cmd_push_o    (cmd_push),
    .cmd_flags_o   (f_flags),
    .cmd_min_sum_o (f_min_sum),
    .cmd_max_sum_o (f_max_sum)
  );

  // Command queue between front and back
  assign cmd_wdata = {f_flags, f_min_sum, f_max_sum};
  assign b_flags   = cmd_flags_t'(cmd_rdata[CmdW-1 -: FlagW]);
  assign b_min_sum = cmd_rdata[2*SumW-1 -: SumW];
  assign b_max_sum = cmd_rdata[SumW-1:0];

  wpd_fifo #(
    .WIDTH (CmdW),
    .DEPTH (2)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (cmd_wdata),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_rdata),
    .full_o  (cmd_full),
    .empty_o (cmd_empty)
  );

  // Back end
  logic      out_push, out_full;
  out_item_t out_item;
  logic [OutW-1:0] out_rdata;

  wpd_back #(
    .SUM_W (SumW)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .cmd_empty_i   (cmd_empty),
    .cmd_flags_i   (b_flags),
    .cmd_min_sum_i (b_min_sum),
    .cmd_max_sum_i (b_max_sum),
    .cmd_pop_o     (cmd_pop),
    .out_full_i    (out_full),
    .out_push_o    (out_push),
    .out_item_o    (out_item)
  );

  // Result queue
  wpd_fifo #(
    .WIDTH (OutW),
    .DEPTH (2)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .wdata_i (out_item),
    .pop_i   (pop),
    .rdata_o (out_rdata),
    .full_o  (out_full),
    .empty_o (empty)
  );

  assign out_item_o = out_item_t'(out_rdata);

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the waveform peak decimator.
// Samples are pushed from a queue of pending items with random gaps. Peak
// pairs are popped with random stalls and one long hold that backs the block
// up. Each pair is checked field by field against an in-bench model of the
// downmix, chunk and mipmap logic. Registers are written on the APB port
// between streams and in mid-stream, and read back after each write.
// ----------------------------------------------------------------------------
module testbench;
  import wpd_pkg::*;

  localparam int CH_LIMIT      = 8;
  localparam int FRAME_LIMIT   = 4096;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 24;
  localparam int ITEM_BUDGET   = 700;
  localparam int CALM_ITEMS    = 560;

  // DUT ports
  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        push      = 1'b0;
  logic        full;
  in_item_t    in_item_i = '0;
  logic        empty;
  logic        pop       = 1'b0;
  out_item_t   out_item_o;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [3:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;

  // Bench bookkeeping
  in_item_t  pending_samples[$];
  out_item_t expected_pairs[$];
  out_item_t pair_batch[$];
  int        items_sent    = 0;
  int        mismatches    = 0;
  int        hold_requests = 0;
  int        holds_served  = 0;
  int        src_wait      = 0;
  int        sink_wait     = 0;
  bit        src_idle_on   = 1'b1;
  bit        sink_idle_on  = 1'b1;

  // Model copy of the registers (raw, clamped on use)
  int cfg_channels = RST_CHANNEL_COUNT;
  int cfg_frames   = RST_CHUNK_FRAMES;
  int cfg_factor   = RST_MIPMAP_FACTOR;

  // Model copy of the stream state
  int mix_pos      = 0;
  int mix_sum      = 0;
  int chunk_lo     = 0;
  int chunk_hi     = 0;
  int chunk_fill   = 0;
  int group_chunks = 0;
  int group_lo     = 0;
  int group_hi     = 0;
  bit group_open   = 1'b0;

  waveform_peak_decimator_unit #(
    .MAX_CHANNELS    (CH_LIMIT),
    .MAX_CHUNK_FRAMES(FRAME_LIMIT)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .in_item_i (in_item_i),
    .empty     (empty),
    .pop       (pop),
    .out_item_o(out_item_o),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Peak decimation model
  // ---------------------------------------------------------------------------
  function automatic int clamp_reg(int v, int hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // sum * 32767 / (ch * 32768), truncated toward zero
  function automatic int scaled_peak(int sum, int ch);
    longint mag;
    longint q;
    mag = (sum < 0) ? -longint'(sum) : longint'(sum);
    q = (mag * 32767) / (longint'(ch) * 32768);
    return (sum < 0) ? -int'(q) : int'(q);
  endfunction

  task automatic add_pair(logic lvl, int mn, int mx);
    out_item_t r;
    r.level    = lvl;
    r.peak_min = 16'(mn);
    r.peak_max = 16'(mx);
    r.last     = 1'b0;
    pair_batch.push_back(r);
  endtask

  task automatic clear_stream();
    mix_pos      = 0;
    mix_sum      = 0;
    chunk_lo     = 0;
    chunk_hi     = 0;
    chunk_fill   = 0;
    group_chunks = 0;
    group_lo     = 0;
    group_hi     = 0;
    group_open   = 1'b0;
  endtask

  // Emit the chunk pair, fold it into the group, close the group when full
  task automatic close_chunk();
    int ch;
    int mf;
    int pmin;
    int pmax;
    ch   = clamp_reg(cfg_channels, CH_LIMIT);
    mf   = clamp_reg(cfg_factor, int'(MAX_MIPMAP));
    pmin = scaled_peak(chunk_lo, ch);
    pmax = scaled_peak(chunk_hi, ch);
    add_pair(LEVEL_CHUNK, pmin, pmax);
    if (pmin < group_lo) group_lo = pmin;
    if (pmax > group_hi) group_hi = pmax;
    if (group_chunks + 1 >= mf) begin
      add_pair(LEVEL_GROUP, group_lo, group_hi);
      group_lo     = 0;
      group_hi     = 0;
      group_chunks = 0;
      group_open   = 1'b0;
    end else begin
      group_chunks++;
      group_open = 1'b1;
    end
    chunk_lo   = 0;
    chunk_hi   = 0;
    chunk_fill = 0;
  endtask

  // One accepted sample: update the model and queue the pairs it causes
  task automatic fold_sample(in_item_t it);
    int ch;
    int cf;
    out_item_t r;
    ch = clamp_reg(cfg_channels, CH_LIMIT);
    cf = clamp_reg(cfg_frames, FRAME_LIMIT);
    pair_batch.delete();
    mix_sum += int'($signed(it.sample));
    if (mix_pos + 1 >= ch) begin
      if (mix_sum < chunk_lo) chunk_lo = mix_sum;
      if (mix_sum > chunk_hi) chunk_hi = mix_sum;
      mix_sum = 0;
      mix_pos = 0;
      if (chunk_fill + 1 >= cf) close_chunk();
      else chunk_fill++;
    end else begin
      mix_pos++;
    end
    // end of stream: drop a partial frame, flush partial chunk and group tail
    if (it.end_of_stream) begin
      if (chunk_fill > 0) close_chunk();
      if (group_open && pair_batch.size() < 2) add_pair(LEVEL_GROUP, group_lo, group_hi);
      clear_stream();
    end
    foreach (pair_batch[i]) begin
      r      = pair_batch[i];
      r.last = (i == pair_batch.size() - 1);
      expected_pairs.push_back(r);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sample driver
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) fold_sample(in_item_i);
      if (!push || !full) begin
        if (src_wait > 0) begin
          src_wait--;
          push <= 1'b0;
        end else if (src_idle_on && pending_samples.size() > 0 &&
                     $urandom_range(0, 7) == 0) begin
          src_wait = $urandom_range(0, 9);
          push <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          push      <= 1'b1;
          in_item_i <= pending_samples.pop_front();
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor
  // ---------------------------------------------------------------------------
  task automatic check_pair(out_item_t got);
    out_item_t want;
    if (expected_pairs.size() == 0) begin
      $error("unexpected result: level %0d min %0d max %0d last %0d",
             got.level, got.peak_min, got.peak_max, got.last);
      mismatches++;
    end else begin
      want = expected_pairs.pop_front();
      if (got.level !== want.level) begin
        $error("level: expected %0d, got %0d", want.level, got.level);
        mismatches++;
      end
      if (got.peak_min !== want.peak_min) begin
        $error("peak_min: expected %0d, got %0d", want.peak_min, got.peak_min);
        mismatches++;
      end
      if (got.peak_max !== want.peak_max) begin
        $error("peak_max: expected %0d, got %0d", want.peak_max, got.peak_max);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) check_pair(out_item_o);
      // long hold on request, else random stall bursts
      if (holds_served != hold_requests) begin
        holds_served++;
        sink_wait = HOLD_CYCLES;
        pop <= 1'b0;
      end else if (sink_wait > 0) begin
        sink_wait--;
        pop <= 1'b0;
      end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
        sink_wait = $urandom_range(0, 9);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // APB write, then read back the masked value
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    logic [31:0] want;
    case (idx)
      REG_CHANNEL_COUNT: want = val & 32'hF;
      REG_CHUNK_FRAMES:  want = val & 32'h1FFF;
      default:           want = val & 32'h7F;
    endcase
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_CHANNEL_COUNT: cfg_channels = int'(want);
      REG_CHUNK_FRAMES:  cfg_frames   = int'(want);
      default:           cfg_factor   = int'(want);
    endcase
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want) begin
      $error("prdata at reg %0d: expected %0d, got %0d", idx, want, prdata);
      mismatches++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Wait until every item is taken and every pair has come out
  task automatic settle();
    do @(negedge clk_i);
    while (pending_samples.size() != 0 || push || expected_pairs.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic enqueue(logic [15:0] s, logic e);
    in_item_t it;
    it.sample        = s;
    it.end_of_stream = e;
    pending_samples.push_back(it);
    items_sent++;
  endtask

  // Biased toward the rails, zero and +/-1
  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0001;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int len;
    int r;
    logic [31:0] val;
    logic eos;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: rails in one partial chunk, flushed with its tail
    @(negedge clk_i);
    enqueue(16'h7FFF, 1'b0);
    enqueue(16'h8000, 1'b0);
    enqueue(16'h0000, 1'b0);
    enqueue(16'hFFFF, 1'b1);
    settle();

    // channel count above range (clamps to 8), one frame per chunk and group
    write_reg(REG_CHANNEL_COUNT, 32'd15);
    write_reg(REG_CHUNK_FRAMES, 32'd1);
    write_reg(REG_MIPMAP_FACTOR, 32'd1);
    @(negedge clk_i);
    repeat (8) enqueue(16'h7FFF, 1'b0);
    // end of stream on a fresh frame: nothing pending, no result
    enqueue(16'h8000, 1'b1);
    settle();

    // zero registers count as 1; chunk length shrinks mid-stream
    write_reg(REG_CHANNEL_COUNT, 32'd0);
    write_reg(REG_CHUNK_FRAMES, 32'd8);
    write_reg(REG_MIPMAP_FACTOR, 32'd0);
    @(negedge clk_i);
    repeat (5) enqueue(pick_sample(), 1'b0);
    settle();
    write_reg(REG_CHUNK_FRAMES, 32'd2);
    @(negedge clk_i);
    enqueue(16'h8000, 1'b1);
    settle();

    // saturating chunk and group sizes; partial frame dropped at stream end
    write_reg(REG_CHANNEL_COUNT, 32'd3);
    write_reg(REG_CHUNK_FRAMES, 32'd8191);
    write_reg(REG_MIPMAP_FACTOR, 32'd127);
    @(negedge clk_i);
    repeat (3) enqueue(16'h8000, 1'b0);
    enqueue(16'h0007, 1'b0);
    enqueue(16'h0008, 1'b1);
    settle();

    // receiver holds off while samples keep coming: block fills and stalls
    write_reg(REG_CHANNEL_COUNT, 32'd1);
    write_reg(REG_CHUNK_FRAMES, 32'd1);
    write_reg(REG_MIPMAP_FACTOR, 32'd2);
    @(negedge clk_i);
    hold_requests++;
    for (int i = 0; i < 40; i++) enqueue(pick_sample(), i == 39);
    settle();

    // random streams, settings changed between and inside streams
    while (items_sent < ITEM_BUDGET) begin
      if ($urandom_range(0, 3) != 0) begin
        r = $urandom_range(0, 9);
        val = (r == 0) ? 32'd0 : (r == 9) ? 32'($urandom_range(9, 15)) : 32'(r);
        write_reg(REG_CHANNEL_COUNT, val);
      end
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 19))
          0:       val = 32'd0;
          1:       val = 32'd4096;
          2:       val = 32'($urandom_range(4097, 8191));
          3:       val = 32'($urandom_range(9, 200));
          default: val = 32'($urandom_range(1, 8));
        endcase
        write_reg(REG_CHUNK_FRAMES, val);
      end
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 15))
          0:       val = 32'd0;
          1:       val = 32'd64;
          2:       val = 32'($urandom_range(65, 127));
          default: val = 32'($urandom_range(1, 6));
        endcase
        write_reg(REG_MIPMAP_FACTOR, val);
      end
      @(negedge clk_i);
      // no idling near the end; otherwise some streams run without gaps
      if (items_sent >= CALM_ITEMS) begin
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
      end else begin
        src_idle_on  = ($urandom_range(0, 3) != 0);
        sink_idle_on = ($urandom_range(0, 3) != 0);
      end
      len = $urandom_range(8, 40);
      for (int k = 0; k < len; k++) begin
        if (k == len - 1) eos = ($urandom_range(0, 3) != 0);
        else eos = ($urandom_range(0, 49) == 0);
        enqueue(pick_sample(), eos);
      end
      settle();
    end

    settle();
    if (mismatches == 0 && expected_pairs.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Run limit
  initial begin
    #6_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/wpd_pkg.sv
rtl/wpd_fifo.sv
rtl/wpd_front.sv
rtl/wpd_div.sv
rtl/wpd_back.sv
rtl/waveform_peak_decimator_unit.sv
bench/testbench.sv
